// ----- rtl/tca_pkg.sv -----
// Shared types and constants for the tick clock with alarm slots.
// No dependencies.
package tca_pkg;

  localparam int MS_W        = 10;
  localparam int SEC_W       = 6;
  localparam int MIN_W       = 6;
  localparam int HOUR_W      = 20;
  localparam int TOTAL_W     = 42;
  localparam int DELAY_W     = 24;
  localparam int SLOT_W      = 3;
  localparam int SIDX_W      = 7;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int MS_PER_SEC  = 1000;
  localparam int SEC_PER_MIN = 60;
  localparam int MIN_PER_HR  = 60;

  localparam logic [TOTAL_W-1:0] TOTAL_SPAN      = 42'd3774873600000;
  localparam logic [MS_W-1:0]    MS_PER_TICK_RST = 10'd10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WAKE       = 2'd0,
    KIND_TIME       = 2'd1,
    KIND_ARM_ACK    = 2'd2,
    KIND_CANCEL_ACK = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic               in_range;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

endpackage

// ----- rtl/tick_clock_with_alarm_slots.sv -----
// Time-of-day clock with alarm slots. Read and cancel pass through S_EXEC and
// S_EMIT, arm through S_EXEC, S_WRAP and S_EMIT; a tick also scans the slots,
// reading one expiry entry per S_SCAN_RD/S_SCAN_CMP pair from its read port.
// A two-word command queue lets input be taken while the back end works.
// Reset (rst_n low, synchronous) clears clock, armed flags and queue and sets
// ms_per_tick to 10; expiry storage is not cleared.
module tick_clock_with_alarm_slots #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [tca_pkg::SLOT_W-1:0]   in_slot,
  input  logic [tca_pkg::DELAY_W-1:0]  in_delay_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [tca_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [tca_pkg::HOUR_W-1:0]   out_hours,
  output logic [tca_pkg::MIN_W-1:0]    out_minutes,
  output logic [tca_pkg::SEC_W-1:0]    out_seconds,
  output logic [tca_pkg::MS_W-1:0]     out_millis,
  output logic [tca_pkg::TOTAL_W-1:0]  out_total_ms,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tca_pkg::MS_W-1:0]     cfg_ms_per_tick
);
  import tca_pkg::*;

  logic [MS_W-1:0] ms_per_tick_r;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_per_tick_r <= MS_PER_TICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      ms_per_tick_r <= cfg_ms_per_tick;
    end
  end

  tca_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_slot      (in_slot),
    .in_delay_ms  (in_delay_ms),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tca_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ms_per_tick  (ms_per_tick_r),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_slot_out (out_slot_out),
    .out_hours    (out_hours),
    .out_minutes  (out_minutes),
    .out_seconds  (out_seconds),
    .out_millis   (out_millis),
    .out_total_ms (out_total_ms),
    .out_last     (out_last)
  );

endmodule

// ----- rtl/tca_front.sv -----
// Front end: accepts input words, decodes them into commands and queues them.
// Depends on tca_pkg.
module tca_front #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [tca_pkg::SLOT_W-1:0]   in_slot,
  input  logic [tca_pkg::DELAY_W-1:0]  in_delay_ms,
  output logic                         cmd_valid,
  output tca_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);
  import tca_pkg::*;

  localparam int QD = 2;

  cmd_t              q_r [QD];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  cmd_t              cmd_new;
  logic [SIDX_W-1:0] slot_ext;
  logic              push;
  logic              pop;

  assign slot_ext         = SIDX_W'(in_slot);
  assign cmd_new.op       = op_t'(in_operation);
  assign cmd_new.slot     = in_slot;
  assign cmd_new.in_range = (slot_ext < SIDX_W'(NUM_SLOTS));
  assign cmd_new.delay    = in_delay_ms;

  assign in_ready  = (cnt_r != 2'(QD));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd_new;
  end

endmodule

// ----- rtl/tca_back.sv -----
// Back end: keeps the clock and alarm table, executes commands, scans slots
// and drives the result register. Depends on tca_pkg.
module tca_back #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tca_pkg::MS_W-1:0]     ms_per_tick,
  input  logic                         cmd_valid,
  input  tca_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [tca_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [tca_pkg::HOUR_W-1:0]   out_hours,
  output logic [tca_pkg::MIN_W-1:0]    out_minutes,
  output logic [tca_pkg::SEC_W-1:0]    out_seconds,
  output logic [tca_pkg::MS_W-1:0]     out_millis,
  output logic [tca_pkg::TOTAL_W-1:0]  out_total_ms,
  output logic                         out_last
);
  import tca_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRAP,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FLUSH
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [HOUR_W-1:0]    hours_r;
  logic [MIN_W-1:0]     min_r;
  logic [SEC_W-1:0]     sec_r;
  logic [MS_W-1:0]      ms_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   sum_r;
  logic [NUM_SLOTS-1:0] armed_r;
  logic [SW-1:0]        scan_idx_r;
  logic [CNT_W-1:0]     found_r;
  logic                 pend_v_r;
  logic [SW-1:0]        pend_slot_r;
  kind_t                emit_kind_r;
  logic [SLOT_W-1:0]    emit_slot_r;
  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_last_r;
  logic [HOUR_W-1:0]    out_hours_r;
  logic [MIN_W-1:0]     out_min_r;
  logic [SEC_W-1:0]     out_sec_r;
  logic [MS_W-1:0]      out_ms_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic [TOTAL_W-1:0]   expiry_mem [NUM_SLOTS];
  logic [TOTAL_W-1:0]   rd_q;

  logic [MS_W:0]        m_sum;
  logic [MS_W-1:0]      ms_adv;
  logic [1:0]           s_carry;
  logic [SEC_W:0]       s_sum;
  logic [SEC_W-1:0]     sec_adv;
  logic                 mi_carry;
  logic [MIN_W:0]       mi_sum;
  logic [MIN_W-1:0]     min_adv;
  logic                 h_carry;
  logic [TOTAL_W-1:0]   wrapped;
  logic [SW-1:0]        cmd_idx;
  logic                 mem_we;
  logic                 due;
  logic                 out_ok;
  logic                 out_load;
  kind_t                load_kind;
  logic [SLOT_W-1:0]    load_slot;
  logic                 load_last;
  logic                 scan_go;

  // clock advance by one tick, carries are at most two seconds deep
  always_comb begin
    m_sum = {1'b0, ms_r} + {1'b0, ms_per_tick};
    if (m_sum >= (MS_W+1)'(2*MS_PER_SEC)) begin
      ms_adv  = MS_W'(m_sum - (MS_W+1)'(2*MS_PER_SEC));
      s_carry = 2'd2;
    end else if (m_sum >= (MS_W+1)'(MS_PER_SEC)) begin
      ms_adv  = MS_W'(m_sum - (MS_W+1)'(MS_PER_SEC));
      s_carry = 2'd1;
    end else begin
      ms_adv  = MS_W'(m_sum);
      s_carry = 2'd0;
    end
    s_sum = {1'b0, sec_r} + (SEC_W+1)'(s_carry);
    if (s_sum >= (SEC_W+1)'(SEC_PER_MIN)) begin
      sec_adv  = SEC_W'(s_sum - (SEC_W+1)'(SEC_PER_MIN));
      mi_carry = 1'b1;
    end else begin
      sec_adv  = SEC_W'(s_sum);
      mi_carry = 1'b0;
    end
    mi_sum = {1'b0, min_r} + (MIN_W+1)'(mi_carry);
    if (mi_sum >= (MIN_W+1)'(MIN_PER_HR)) begin
      min_adv = MIN_W'(mi_sum - (MIN_W+1)'(MIN_PER_HR));
      h_carry = 1'b1;
    end else begin
      min_adv = MIN_W'(mi_sum);
      h_carry = 1'b0;
    end
  end

  assign wrapped = (sum_r >= TOTAL_SPAN) ? (sum_r - TOTAL_SPAN) : sum_r;
  assign cmd_idx = SW'(cmd_r.slot);
  assign mem_we  = (state_r == S_WRAP) && (cmd_r.op == OP_ARM) && cmd_r.in_range;
  assign due     = armed_r[scan_idx_r] && (rd_q <= total_r);
  assign out_ok  = !out_valid_r || out_ready;
  assign cmd_pop = (state_r == S_IDLE);
  assign scan_go = !(due && pend_v_r && !out_ok);

  always_comb begin
    out_load  = 1'b0;
    load_kind = emit_kind_r;
    load_slot = emit_slot_r;
    load_last = 1'b1;
    case (state_r)
      S_EMIT: out_load = out_ok;
      S_SCAN_CMP: begin
        out_load  = due && pend_v_r && out_ok;
        load_kind = KIND_WAKE;
        load_slot = SLOT_W'(SIDX_W'(pend_slot_r));
        load_last = 1'b0;
      end
      S_FLUSH: begin
        out_load  = pend_v_r && out_ok;
        load_kind = KIND_WAKE;
        load_slot = SLOT_W'(SIDX_W'(pend_slot_r));
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) expiry_mem[cmd_idx] <= wrapped;
    rd_q <= expiry_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hours_r     <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      ms_r        <= '0;
      total_r     <= '0;
      armed_r     <= '0;
      scan_idx_r  <= '0;
      found_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (out_load) begin
        out_kind_r  <= load_kind;
        out_slot_r  <= load_slot;
        out_last_r  <= load_last;
        out_hours_r <= hours_r;
        out_min_r   <= min_r;
        out_sec_r   <= sec_r;
        out_ms_r    <= ms_r;
        out_total_r <= total_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_r.op)
            OP_TICK: begin
              ms_r    <= ms_adv;
              sec_r   <= sec_adv;
              min_r   <= min_adv;
              hours_r <= hours_r + HOUR_W'(h_carry);
              sum_r   <= total_r + TOTAL_W'(ms_per_tick);
              state_r <= S_WRAP;
            end
            OP_ARM: begin
              sum_r   <= total_r + TOTAL_W'(cmd_r.delay);
              state_r <= S_WRAP;
            end
            OP_CANCEL: begin
              if (cmd_r.in_range) armed_r[cmd_idx] <= 1'b0;
              emit_kind_r <= KIND_CANCEL_ACK;
              emit_slot_r <= cmd_r.slot;
              state_r     <= S_EMIT;
            end
            OP_READ: begin
              emit_kind_r <= KIND_TIME;
              emit_slot_r <= '0;
              state_r     <= S_EMIT;
            end
          endcase
        end
        S_WRAP: begin
          if (cmd_r.op == OP_TICK) begin
            total_r    <= wrapped;
            scan_idx_r <= '0;
            found_r    <= '0;
            pend_v_r   <= 1'b0;
            state_r    <= S_SCAN_RD;
          end else begin
            if (cmd_r.in_range) armed_r[cmd_idx] <= 1'b1;
            emit_kind_r <= KIND_ARM_ACK;
            emit_slot_r <= cmd_r.slot;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ok) state_r <= S_IDLE;
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (scan_go) begin
            if (due) begin
              armed_r[scan_idx_r] <= 1'b0;
              pend_slot_r         <= scan_idx_r;
              pend_v_r            <= 1'b1;
              found_r             <= found_r + CNT_W'(1);
            end
            if ((scan_idx_r == SW'(NUM_SLOTS-1)) ||
                (due && (found_r == CNT_W'(MAX_RESULTS-1)))) begin
              state_r <= S_FLUSH;
            end else begin
              scan_idx_r <= scan_idx_r + SW'(1);
              state_r    <= S_SCAN_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (out_ok) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_slot_out = out_slot_r;
  assign out_hours    = out_hours_r;
  assign out_minutes  = out_min_r;
  assign out_seconds  = out_sec_r;
  assign out_millis   = out_ms_r;
  assign out_total_ms = out_total_r;
  assign out_last     = out_last_r;

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r < TOTAL_SPAN)
    else $error("total out of range");

  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ms_r < MS_W'(MS_PER_SEC)) && (sec_r < SEC_W'(SEC_PER_MIN)) &&
    (min_r < MIN_W'(MIN_PER_HR)))
    else $error("clock field out of range");

  a_found_max: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= CNT_W'(MAX_RESULTS))
    else $error("too many wakes");

  a_nonlast_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_kind_r == KIND_WAKE))
    else $error("non-final word is not a wake");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |->
      ($past(state_r) == S_SCAN_RD || $past(state_r) == S_SCAN_CMP))
    else $error("compare without read");

endmodule
